[sv/wavetable_sound_generator_top_macros.svh]
// Assertion helpers for the checker file.
`ifndef WAVETABLE_SOUND_GENERATOR_TOP_MACROS_SVH
`define WAVETABLE_SOUND_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WSG_ASSERT_IMP(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("wsg check failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define WSG_ASSERT_NXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("wsg check failed: next-cycle implication");

`endif

[sv/wsg_pkg.sv]
`default_nettype none

package wsg_pkg;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_REG  = 2'd1,
    CMD_WAVE = 2'd2
  } wsg_cmd_code_t;

  typedef enum logic [1:0] {
    SEL_PAGE    = 2'd0,
    SEL_CTRL    = 2'd1,
    SEL_FREQ_HI = 2'd2,
    SEL_FREQ_LO = 2'd3
  } wsg_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MULT,
    ST_LOAD
  } wsg_state_t;

  // Controller to datapath
  typedef struct packed {
    logic reg_wr;
    logic wave_wr;
    logic tick_start;
    logic scan_en;
    logic mult_en;
    logic load_out;
  } wsg_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_voice;
    logic out_busy;
  } wsg_sts_t;

  localparam int CFG_AW = 3;
  localparam logic REG_GAIN = 1'b0;
  localparam logic [7:0] GAIN_RESET = 8'd25;
  localparam int PHASE_W = 21;

endpackage

`default_nettype wire

[sv/wsg_ram.sv]
`default_nettype none

module wsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/wsg_cfg.sv]
`default_nettype none

module wsg_cfg
  import wsg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready,
  output logic      [7:0]        gain
);

  logic [7:0] gain_r;
  logic       hit_gain;

  assign hit_gain   = (cfg_paddr[CFG_AW-1:2] == REG_GAIN);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = hit_gain ? {24'h000000, gain_r} : 32'h00000000;
  assign gain       = gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && hit_gain) begin
      gain_r <= cfg_pwdata[7:0];
    end
  end

endmodule

`default_nettype wire

[sv/wsg_ctrl.sv]
`default_nettype none

module wsg_ctrl
  import wsg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_cmd,
  input  wire wsg_sts_t   sts,
  output logic            in_stall,
  output wsg_cmd_t        cmd
);

  wsg_state_t state_r, state_nxt;
  logic       take;

  assign take = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take && (wsg_cmd_code_t'(in_cmd) == CMD_TICK)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.last_voice) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_MULT;
      ST_MULT:  state_nxt = ST_LOAD;
      ST_LOAD: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        case (wsg_cmd_code_t'(in_cmd))
          CMD_TICK: cmd.tick_start = take;
          CMD_REG:  cmd.reg_wr     = take;
          CMD_WAVE: cmd.wave_wr    = take;
          default:  cmd            = '0;
        endcase
      end
      ST_SCAN:  cmd.scan_en  = 1'b1;
      ST_MULT:  cmd.mult_en  = 1'b1;
      ST_LOAD:  cmd.load_out = !sts.out_busy;
      default:  cmd          = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/wsg_datapath.sv]
`default_nettype none

module wsg_datapath
  import wsg_pkg::*;
#(
  parameter int VOICES     = 8,
  parameter int WAVE_BYTES = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire wsg_cmd_t           cmd,
  output wsg_sts_t                sts,
  input  wire logic [2:0]         in_voice,
  input  wire logic [1:0]         in_reg_select,
  input  wire logic [9:0]         in_wave_address,
  input  wire logic [7:0]         in_write_value,
  input  wire logic [7:0]         gain,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic signed [15:0]      out_sample_out
);

  localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int WA_W  = $clog2(WAVE_BYTES);
  localparam int SUM_W = 10 + $clog2(VOICES);
  localparam int PW    = SUM_W + 9;
  localparam logic signed [PW-1:0] SAT_MAX = PW'(32767);
  localparam logic signed [PW-1:0] SAT_MIN = -PW'(32768);

  logic [PHASE_W-1:0] phase_r [VOICES];
  logic [7:0]         page_r  [VOICES];
  logic [7:0]         ctrl_r  [VOICES];
  logic [15:0]        freq_r  [VOICES];

  logic [VW-1:0]      vcnt_r;
  logic               s1_act_r;
  logic [3:0]         s1_vol_r;
  logic               s1_odd_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [PW-1:0]    prod_r;
  logic               out_valid_r;
  logic signed [15:0] sample_r;

  logic [4:0]         voice_x;
  logic [VW-1:0]      widx;
  logic               wr_ok;
  logic [7:0]         cur_ctrl;
  logic [15:0]        cur_freq;
  logic [3:0]         cur_vol;
  logic [3:0]         cur_wave;
  logic               act;
  logic [PHASE_W-1:0] phase_nxt;
  logic [8:0]         pos;
  logic [15:0]        byte_addr;
  logic [15:0]        wr_addr;
  logic [7:0]         rdata;
  logic [3:0]         nib;
  logic signed [9:0]  term;
  logic signed [15:0] sat;

  assign voice_x = {2'b00, in_voice};
  assign widx    = voice_x[VW-1:0];
  assign wr_ok   = cmd.reg_wr && (voice_x < 5'(VOICES));

  assign cur_ctrl  = ctrl_r[vcnt_r];
  assign cur_freq  = freq_r[vcnt_r];
  assign cur_vol   = cur_ctrl[7:4];
  assign cur_wave  = cur_ctrl[3:0];
  assign act       = cmd.scan_en && (cur_vol != 4'd0) && (cur_freq != 16'd0);
  assign phase_nxt = phase_r[vcnt_r] + {5'b00000, cur_freq};
  assign pos       = {1'b0, cur_wave, 4'b0000} + {4'b0000, phase_nxt[20:16]};
  assign byte_addr = {page_r[vcnt_r], 8'h00} + {8'h00, pos[8:1]};
  assign wr_addr   = {6'b000000, in_wave_address};

  wsg_ram #(
    .WIDTH (8),
    .DEPTH (WAVE_BYTES)
  ) u_wave (
    .clk     (clk),
    .we      (cmd.wave_wr),
    .waddr   (wr_addr[WA_W-1:0]),
    .wdata   (in_write_value),
    .raddr   (byte_addr[WA_W-1:0]),
    .rdata_r (rdata)
  );

  // even positions sit in the high nibble
  assign nib  = s1_odd_r ? rdata[3:0] : rdata[7:4];
  assign term = ($signed({1'b0, nib}) - 5'sd8) * $signed({1'b0, s1_vol_r});

  always_comb begin
    if (prod_r > SAT_MAX) begin
      sat = 16'sh7FFF;
    end else if (prod_r < SAT_MIN) begin
      sat = -16'sh8000;
    end else begin
      sat = prod_r[15:0];
    end
  end

  assign sts.last_voice = (vcnt_r == VW'(VOICES - 1));
  assign sts.out_busy   = out_valid_r && out_stall;
  assign out_valid      = out_valid_r;
  assign out_sample_out = sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        phase_r[i] <= '0;
        page_r[i]  <= '0;
        ctrl_r[i]  <= '0;
        freq_r[i]  <= '0;
      end
    end else begin
      if (act) begin
        phase_r[vcnt_r] <= phase_nxt;
      end
      if (wr_ok) begin
        case (wsg_sel_t'(in_reg_select))
          SEL_PAGE:    page_r[widx]       <= in_write_value;
          SEL_CTRL:    ctrl_r[widx]       <= in_write_value;
          SEL_FREQ_HI: freq_r[widx][15:8] <= in_write_value;
          SEL_FREQ_LO: freq_r[widx][7:0]  <= in_write_value;
          default:     page_r[widx]       <= page_r[widx];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r      <= '0;
      s1_act_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.tick_start) begin
        vcnt_r <= '0;
      end else if (cmd.scan_en) begin
        vcnt_r <= vcnt_r + VW'(1);
      end
      s1_act_r <= act;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_vol_r <= cur_vol;
    s1_odd_r <= pos[0];
    if (cmd.tick_start) begin
      sum_r <= '0;
    end else if (s1_act_r) begin
      sum_r <= sum_r + SUM_W'(term);
    end
    if (cmd.mult_en) begin
      prod_r <= sum_r * $signed({1'b0, gain});
    end
    if (cmd.load_out) begin
      sample_r <= sat;
    end
  end

endmodule

`default_nettype wire

[sv/wavetable_sound_generator_top.sv]
`default_nettype none

// Wavetable sound generator: up to VOICES voices, each with page, control
// (volume in the high nibble, wave number in the low nibble) and a 16-bit
// frequency, reading 4-bit samples from a WAVE_BYTES byte wave RAM.
// Register and wave writes (cmd 1 and 2) return nothing.
// A tick (cmd 0) returns one saturated sample: the block accepts it, reads
// one voice at a time on the single wave RAM read port, drains the RAM read,
// does the gain multiply and loads the output register; the block stalls its
// input for the rest of that time, and waits longer only while an earlier
// sample is still held in the output register. WAVE_BYTES must be a power of
// two; wave addresses wrap at the end of the store. Read only wave entries
// that were written first.
module wavetable_sound_generator_top
  import wsg_pkg::*;
#(
  parameter int VOICES     = 8,
  parameter int WAVE_BYTES = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_cmd,
  input  wire logic [2:0]         in_voice,
  input  wire logic [1:0]         in_reg_select,
  input  wire logic [9:0]         in_wave_address,
  input  wire logic [7:0]         in_write_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_sample_out,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [CFG_AW-1:0]  cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic      [31:0]        cfg_prdata,
  output logic                    cfg_pready
);

  wsg_cmd_t   cmd;
  wsg_sts_t   sts;
  logic [7:0] gain;

  wsg_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .gain        (gain)
  );

  wsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  wsg_datapath #(
    .VOICES     (VOICES),
    .WAVE_BYTES (WAVE_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_voice        (in_voice),
    .in_reg_select   (in_reg_select),
    .in_wave_address (in_wave_address),
    .in_write_value  (in_write_value),
    .gain            (gain),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_sample_out  (out_sample_out)
  );

endmodule

`default_nettype wire

[sv/wsg_checker.sv]
`default_nettype none

`include "wavetable_sound_generator_top_macros.svh"

module wsg_checker
  import wsg_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [1:0] in_cmd,
  input wire logic       out_valid,
  input wire logic       out_stall
);

  // a tick request keeps the block busy in the next cycle
  `WSG_ASSERT_NXT(a_tick_busy, clk, rst_n, in_valid && !in_stall && in_cmd == CMD_TICK, in_stall)

  // writes and unused codes finish in the cycle they are taken
  `WSG_ASSERT_NXT(a_write_fast, clk, rst_n, in_valid && !in_stall && in_cmd != CMD_TICK, !in_stall)

  // a sample appears only at the end of a busy period
  `WSG_ASSERT_IMP(a_out_after_busy, clk, rst_n, $rose(out_valid), $past(in_stall))

  // a stalled sample is held
  `WSG_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

endmodule

bind wavetable_sound_generator_top wsg_checker u_wsg_checker (.*);

`default_nettype wire
